/* rtl/core/kil_pkg.sv */
// Shared types, keyword table and character helpers for the keyword/identifier lexer.
package kil_pkg;

    localparam int MAX_LEN_DEF = 32;
    localparam int KW_COUNT    = 22;
    localparam int KW_MAX_LEN  = 8;
    localparam int KW_ID_W     = 5;
    localparam int KW_IDX_W    = 3;
    localparam int CHAR_W      = 8;
    localparam int USER_W      = 7;

    localparam logic [KW_ID_W-1:0] KW_NONE  = KW_ID_W'(22);
    localparam logic [KW_ID_W-1:0] KW_LAST  = KW_ID_W'(KW_COUNT);

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_KW_SCAN,
        ST_KW_CMP,
        ST_EMIT
    } kil_state_t;

    // Token buffer controls from the sequencer.
    typedef struct packed {
        logic push;
        logic clear;
        logic rd_en;
    } kil_buf_ctrl_t;

    function automatic logic is_word_char(input logic [CHAR_W-1:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               (c == "_") || (c >= "0" && c <= "9");
    endfunction

    // Keyword length; 0 for any index outside the table.
    function automatic logic [3:0] kw_len(input logic [KW_ID_W-1:0] k);
        logic [3:0] l;
        unique case (k)
            5'd0:    l = 4'd2;  // if
            5'd1:    l = 4'd4;  // else
            5'd2:    l = 4'd5;  // while
            5'd3:    l = 4'd2;  // do
            5'd4:    l = 4'd5;  // break
            5'd5:    l = 4'd8;  // continue
            5'd6:    l = 4'd3;  // int
            5'd7:    l = 4'd6;  // double
            5'd8:    l = 4'd5;  // float
            5'd9:    l = 4'd6;  // return
            5'd10:   l = 4'd4;  // char
            5'd11:   l = 4'd4;  // case
            5'd12:   l = 4'd6;  // sizeof
            5'd13:   l = 4'd4;  // long
            5'd14:   l = 4'd5;  // short
            5'd15:   l = 4'd7;  // typedef
            5'd16:   l = 4'd6;  // switch
            5'd17:   l = 4'd8;  // unsigned
            5'd18:   l = 4'd4;  // void
            5'd19:   l = 4'd6;  // static
            5'd20:   l = 4'd6;  // struct
            5'd21:   l = 4'd4;  // goto
            default: l = 4'd0;
        endcase
        return l;
    endfunction

    // Keyword text, last character in the low byte.
    function automatic logic [63:0] kw_text(input logic [KW_ID_W-1:0] k);
        logic [63:0] t;
        unique case (k)
            5'd0:    t = 64'("if");
            5'd1:    t = 64'("else");
            5'd2:    t = 64'("while");
            5'd3:    t = 64'("do");
            5'd4:    t = 64'("break");
            5'd5:    t = 64'("continue");
            5'd6:    t = 64'("int");
            5'd7:    t = 64'("double");
            5'd8:    t = 64'("float");
            5'd9:    t = 64'("return");
            5'd10:   t = 64'("char");
            5'd11:   t = 64'("case");
            5'd12:   t = 64'("sizeof");
            5'd13:   t = 64'("long");
            5'd14:   t = 64'("short");
            5'd15:   t = 64'("typedef");
            5'd16:   t = 64'("switch");
            5'd17:   t = 64'("unsigned");
            5'd18:   t = 64'("void");
            5'd19:   t = 64'("static");
            5'd20:   t = 64'("struct");
            5'd21:   t = 64'("goto");
            default: t = 64'd0;
        endcase
        return t;
    endfunction

    // Character i of keyword k, counted from the first character.
    function automatic logic [CHAR_W-1:0] kw_char(input logic [KW_ID_W-1:0] k,
                                                  input logic [KW_IDX_W-1:0] i);
        logic [63:0]         t;
        logic [KW_IDX_W-1:0] pos;
        logic [63:0]         sh;
        t   = kw_text(k);
        pos = KW_IDX_W'(kw_len(k) - 4'd1 - {1'b0, i});
        sh  = t >> {pos, 3'b000};
        return sh[CHAR_W-1:0];
    endfunction

endpackage

/* rtl/core/keyword_identifier_lexer.sv */
// Top level of the keyword/identifier lexer: stream ports and match/emit sequencer.
//
// Usage:
//   s_ channel carries one text byte per item in s_tdata. Letters, digits and
//   underscore build up a token; any other byte is a delimiter.
//   A delimiter after a non-empty token produces a run of items on the m_
//   channel, one token character each, first character first, with m_tlast
//   on the final one. m_tuser carries the class of the whole token.
//   Flow:
//     word character or delimiter after nothing: s_tready stays high.
//     delimiter ending a token of length L: keyword search over the table,
//       stepping past each keyword of another length and comparing the
//       characters of a keyword of the same length one by one (skipped
//       when the token is longer than 8 or truncated), then L output
//       items at one item per cycle while m_tready is high.
//   The search uses a single byte comparator walking keyword by keyword over
//   the one read port of the token store.
//   s_tready is low from the delimiter until the last character is taken.
//   A stall on m_tready holds the current item; nothing is lost.
//   Reset (aresetn low, synchronous) empties the token and returns to input.
//   A token with no delimiter after it stays buffered.
module keyword_identifier_lexer #(
    parameter int MAX_LEN = kil_pkg::MAX_LEN_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // input bytes
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [7:0] ch
    // token characters
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,   // [7:0] token_char
    output logic [kil_pkg::USER_W-1:0] m_tuser,   // [0] is_keyword, [5:1] keyword_id,
                                                  // [6] truncated
    output logic                       m_tlast
);
    import kil_pkg::*;

    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int ADDR_W = $clog2(MAX_LEN);

    kil_state_t          state_reg, state_next;
    logic [KW_ID_W-1:0]  k_reg, k_next;     // keyword under test
    logic [KW_IDX_W-1:0] i_reg, i_next;     // character within keyword
    logic [ADDR_W-1:0]   j_reg, j_next;     // output character index
    logic [KW_ID_W-1:0]  id_reg, id_next;

    kil_buf_ctrl_t       buf_ctrl;
    logic [ADDR_W-1:0]   rd_addr;
    logic [CHAR_W-1:0]   rd_data;
    logic [LEN_W-1:0]    len;
    logic                ovf;

    logic                in_acc;
    logic                out_acc;
    logic                in_word;
    logic                kw_skip;       // token cannot be a keyword
    logic                len_eq;
    logic                chr_eq;
    logic                chr_done;
    logic                emit_last;

    kil_token_buf #(
        .MAX_LEN (MAX_LEN),
        .LEN_W   (LEN_W),
        .ADDR_W  (ADDR_W)
    ) u_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (buf_ctrl),
        .push_char (s_tdata),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .len       (len),
        .ovf       (ovf)
    );

    assign in_acc    = s_tvalid && s_tready;
    assign out_acc   = m_tvalid && m_tready;
    assign in_word   = is_word_char(s_tdata);
    assign kw_skip   = ovf || (len > LEN_W'(KW_MAX_LEN)) || (k_reg == KW_LAST);
    assign len_eq    = (LEN_W'(kw_len(k_reg)) == len);
    assign chr_eq    = (rd_data == kw_char(k_reg, i_reg));
    assign chr_done  = (LEN_W'(i_reg) + LEN_W'(1) == len);
    assign emit_last = (LEN_W'(j_reg) + LEN_W'(1) == len);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_COLLECT: begin
                if (in_acc && !in_word && len != '0) begin
                    state_next = ST_KW_SCAN;
                end
            end
            ST_KW_SCAN: begin
                if (kw_skip) begin
                    state_next = ST_EMIT;
                end else if (len_eq) begin
                    state_next = ST_KW_CMP;
                end
            end
            ST_KW_CMP: begin
                if (chr_eq && chr_done) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_KW_SCAN;
                end
            end
            ST_EMIT: begin
                if (out_acc && emit_last) begin
                    state_next = ST_COLLECT;
                end
            end
            default: state_next = ST_COLLECT;
        endcase
    end

    // datapath controls and counters
    always_comb begin
        buf_ctrl = '0;
        rd_addr  = '0;
        k_next   = k_reg;
        i_next   = i_reg;
        j_next   = j_reg;
        id_next  = id_reg;
        unique case (state_reg)
            ST_COLLECT: begin
                k_next = '0;
                i_next = '0;
                if (in_acc) begin
                    buf_ctrl.push  = in_word;
                    buf_ctrl.clear = !in_word && (len == '0);
                end
            end
            ST_KW_SCAN: begin
                if (kw_skip) begin
                    id_next         = KW_NONE;
                    j_next          = '0;
                    buf_ctrl.rd_en  = 1'b1;   // prefetch first character
                end else if (len_eq) begin
                    buf_ctrl.rd_en  = 1'b1;
                    rd_addr         = ADDR_W'(i_reg);
                end else begin
                    k_next = k_reg + KW_ID_W'(1);
                end
            end
            ST_KW_CMP: begin
                if (!chr_eq) begin
                    k_next = k_reg + KW_ID_W'(1);
                    i_next = '0;
                end else if (chr_done) begin
                    id_next        = k_reg;
                    j_next         = '0;
                    buf_ctrl.rd_en = 1'b1;
                end else begin
                    i_next = i_reg + KW_IDX_W'(1);
                end
            end
            ST_EMIT: begin
                if (out_acc) begin
                    if (emit_last) begin
                        buf_ctrl.clear = 1'b1;
                    end else begin
                        j_next         = j_reg + ADDR_W'(1);
                        buf_ctrl.rd_en = 1'b1;
                        rd_addr        = j_reg + ADDR_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_COLLECT;
            k_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            id_reg    <= KW_NONE;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            id_reg    <= id_next;
        end
    end

    // the registered store output is the output register during emission
    assign s_tready = (state_reg == ST_COLLECT);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tdata  = rd_data;
    assign m_tuser  = {ovf, id_reg, (id_reg != KW_NONE)};
    assign m_tlast  = emit_last;

    // checks
    a_emit_has_token: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (len != '0))
        else $error("emitting with empty token");

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input open while emitting");

    a_last_reopens: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && len == '0 && !ovf))
        else $error("token not cleared after last item");

    a_cmp_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_KW_CMP) |-> (LEN_W'(i_reg) < len && k_reg < KW_LAST))
        else $error("compare index out of range");

    a_kw_not_trunc: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> !m_tuser[6])
        else $error("truncated token flagged as keyword");

endmodule

/* rtl/core/kil_token_buf.sv */
// Token buffer: character store, fill length, overflow flag and registered read port.
module kil_token_buf #(
    parameter int MAX_LEN = kil_pkg::MAX_LEN_DEF,
    parameter int LEN_W   = $clog2(MAX_LEN + 1),
    parameter int ADDR_W  = $clog2(MAX_LEN)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  kil_pkg::kil_buf_ctrl_t     ctrl,
    input  logic [kil_pkg::CHAR_W-1:0] push_char,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [kil_pkg::CHAR_W-1:0] rd_data,
    output logic [LEN_W-1:0]           len,
    output logic                       ovf
);
    import kil_pkg::*;

    logic [CHAR_W-1:0] mem [MAX_LEN];
    logic [CHAR_W-1:0] rd_data_reg;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              ovf_reg, ovf_next;
    logic              full;
    logic              wr_en;

    assign full  = (len_reg == LEN_W'(MAX_LEN));
    assign wr_en = ctrl.push && !full;

    always_comb begin
        len_next = len_reg;
        ovf_next = ovf_reg;
        if (ctrl.clear) begin
            len_next = '0;
            ovf_next = 1'b0;
        end else if (ctrl.push) begin
            if (full) begin
                ovf_next = 1'b1;
            end else begin
                len_next = len_reg + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
            ovf_reg <= 1'b0;
        end else begin
            len_reg <= len_next;
            ovf_reg <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[len_reg[ADDR_W-1:0]] <= push_char;
        end
        if (ctrl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign len     = len_reg;
    assign ovf     = ovf_reg;

endmodule
